/* rtl/core/uart_boot_loader_stream_assert.svh */
// ----------------------------------------------------------------------------
// UART boot loader stream assertion macros
// Shared property forms for the checkers of the boot loader stream.
// ----------------------------------------------------------------------------
`ifndef UART_BOOT_LOADER_STREAM_ASSERT_SVH
`define UART_BOOT_LOADER_STREAM_ASSERT_SVH

// same-cycle implication
`define UBL_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UBL_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ubl_pkg.sv */
// ----------------------------------------------------------------------------
// UART boot loader stream package
// Modes, result kinds, protocol characters and shared structs.
// ----------------------------------------------------------------------------
package ubl_pkg;

   typedef enum logic [1:0] {
      MODE_CMD  = 2'd0,
      MODE_HDR  = 2'd1,
      MODE_DATA = 2'd2,
      MODE_RUN  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ECHO   = 3'd0,
      KIND_LINE   = 3'd1,
      KIND_WRITE  = 3'd2,
      KIND_HDR    = 3'd3,
      KIND_LAUNCH = 3'd4
   } kind_type;

   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] LAST_RESET = 8'hFF;

   typedef struct packed {
      logic       fire;
      logic [7:0] rx_byte;
   } step_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  echo_byte;
      logic [31:0] write_addr;
      logic [7:0]  write_data;
      logic [31:0] launch_addr;
   } result_type;

endpackage

/* rtl/core/ubl_core.sv */
// ----------------------------------------------------------------------------
// UART boot loader stream core
// Loader state and per-byte decode: echo, blob header/data, launch address.
// ----------------------------------------------------------------------------
module ubl_core import ubl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  step_type   step,
   output result_type result
);

   mode_type    mode_ff, mode_in;
   logic [2:0]  hdr_ff, hdr_in;
   logic [31:0] tgt_ff, tgt_in;
   logic [31:0] len_ff, len_in;
   logic [7:0]  last_ff, last_in;
   logic [31:0] lane;
   logic [2:0]  hdr_inc;

   always_comb begin
      lane    = {24'd0, step.rx_byte} << {hdr_ff[1:0], 3'b000};
      hdr_inc = hdr_ff + 3'd1;
      mode_in = mode_ff;
      hdr_in  = hdr_ff;
      tgt_in  = tgt_ff;
      len_in  = len_ff;
      last_in = last_ff;
      result  = '0;
      result.kind = KIND_ECHO;
      unique case (mode_ff)
         MODE_CMD: begin
            result.echo_byte = step.rx_byte;
            if (step.rx_byte == CHAR_CR) begin
               if (last_ff == CHAR_B) begin
                  mode_in = MODE_HDR;
                  hdr_in  = 3'd0;
                  tgt_in  = 32'd0;
                  len_in  = 32'd0;
               end else if (last_ff == CHAR_R) begin
                  mode_in = MODE_RUN;
                  hdr_in  = 3'd0;
                  tgt_in  = 32'd0;
               end else begin
                  result.kind = KIND_LINE;
               end
            end
            last_in = step.rx_byte;
         end
         MODE_HDR: begin
            result.kind = KIND_HDR;
            if (!hdr_ff[2]) begin
               tgt_in = tgt_ff | lane;
            end else begin
               len_in = len_ff | lane;
            end
            hdr_in = hdr_inc;
            if (hdr_inc == 3'd0) begin
               mode_in = (len_in == 32'd0) ? MODE_CMD : MODE_DATA;
            end
         end
         MODE_DATA: begin
            result.kind       = KIND_WRITE;
            result.write_addr = tgt_ff;
            result.write_data = step.rx_byte;
            tgt_in = tgt_ff + 32'd1;
            len_in = len_ff - 32'd1;
            if (len_ff == 32'd1) begin
               mode_in = MODE_CMD;
            end
         end
         MODE_RUN: begin
            tgt_in = tgt_ff | lane;
            hdr_in = hdr_inc;
            if (hdr_inc[2]) begin
               result.kind        = KIND_LAUNCH;
               result.launch_addr = tgt_in;
               hdr_in  = 3'd0;
               mode_in = MODE_CMD;
            end else begin
               result.kind = KIND_HDR;
            end
         end
         default: begin
            mode_in = MODE_CMD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CMD;
         hdr_ff  <= 3'd0;
         tgt_ff  <= 32'd0;
         len_ff  <= 32'd0;
         last_ff <= LAST_RESET;
      end else if (step.fire) begin
         mode_ff <= mode_in;
         hdr_ff  <= hdr_in;
         tgt_ff  <= tgt_in;
         len_ff  <= len_in;
         last_ff <= last_in;
      end
   end

endmodule

/* rtl/core/uart_boot_loader_stream.sv */
// An accepted item moves from the input register into the result register.
// Throughput: one item per cycle while the result channel is not stalled; decode in ubl_core is combinational.
// A full result register that is stalled holds one item; one more waits in the input register.
// Reset (synchronous): command mode, counters and cursors zero, previous byte 0xFF,
// both registers empty.
// ----------------------------------------------------------------------------
// UART boot loader stream
// Turns received bytes into echo, line end, header, memory write and launch items.
// ----------------------------------------------------------------------------
module uart_boot_loader_stream import ubl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [7:0]  rsp_echo_byte,
   output logic [31:0] rsp_write_addr,
   output logic [7:0]  rsp_write_data,
   output logic [31:0] rsp_launch_addr
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   result_type result;
   step_type   step;
   logic       advance;
   logic       req_accept;

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign step.fire    = advance;
   assign step.rx_byte = in_byte_ff;

   ubl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_res_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_res_ff.kind;
   assign rsp_echo_byte   = out_res_ff.echo_byte;
   assign rsp_write_addr  = out_res_ff.write_addr;
   assign rsp_write_data  = out_res_ff.write_data;
   assign rsp_launch_addr = out_res_ff.launch_addr;

endmodule

/* rtl/core/uart_boot_loader_stream_chk.sv */
// ----------------------------------------------------------------------------
// UART boot loader stream checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "uart_boot_loader_stream_assert.svh"

module uart_boot_loader_stream_chk import ubl_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_result_kind,
   input logic [7:0]  rsp_echo_byte,
   input logic [31:0] rsp_write_addr,
   input logic [7:0]  rsp_write_data,
   input logic [31:0] rsp_launch_addr
);

   `UBL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_write_addr), "stalled result item changed")

   `UBL_ASSERT_IMP(a_line_cr, clock, reset, rsp_valid && rsp_result_kind == KIND_LINE, rsp_echo_byte == CHAR_CR, "line end item without carriage return")

   `UBL_ASSERT_IMP(a_echo_clean, clock, reset, rsp_valid && (rsp_result_kind == KIND_ECHO || rsp_result_kind == KIND_LINE), rsp_write_addr == 32'd0 && rsp_write_data == 8'd0 && rsp_launch_addr == 32'd0, "echo item carries write or launch data")

   `UBL_ASSERT_IMP(a_write_clean, clock, reset, rsp_valid && rsp_result_kind == KIND_WRITE, rsp_echo_byte == 8'd0 && rsp_launch_addr == 32'd0, "write item carries echo or launch data")

endmodule

bind uart_boot_loader_stream uart_boot_loader_stream_chk u_chk (.*);

/* sim/tb_uart_boot_loader_stream.sv */
// ----------------------------------------------------------------------------
// UART boot loader stream testbench
// Feeds received bytes through the boot loader: command echo, line ends,
// blob loads with wrapping addresses, zero-length blobs, launches and stray
// bytes. A byte-level model of the loader predicts every result item, and a
// monitor compares each one field by field. Both sides idle and stall at
// random, the receiver holds off for long stretches, and the sender sometimes
// waits for the block to drain.
// ----------------------------------------------------------------------------
module tb_uart_boot_loader_stream import ubl_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned RANDOM_BYTES = 800;
   localparam int unsigned MAX_PRINTED = 50;

   typedef struct packed {
      logic [7:0] value;
      logic [4:0] gap_after;
      logic       drain_first;
   } rx_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_result_kind;
   logic [7:0]  rsp_echo_byte;
   logic [31:0] rsp_write_addr;
   logic [7:0]  rsp_write_data;
   logic [31:0] rsp_launch_addr;

   rx_item_type pending_bytes[$];
   result_type  expected_results[$];
   rx_item_type next_item;
   result_type  expected_now;

   mode_type    load_mode = MODE_CMD;
   logic [2:0]  hdr_count = 3'd0;
   logic [31:0] cursor = 32'd0;
   logic [31:0] blob_left = 32'd0;
   logic [7:0]  prev_cmd_byte = LAST_RESET;

   int unsigned bytes_queued = 0;
   int unsigned bytes_accepted = 0;
   int unsigned results_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned kind_seen[5] = '{default: 0};
   int unsigned hold_offs = 0;
   int unsigned drain_pauses = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   logic        hold_request = 1'b0;
   bit          receiver_calm = 1'b0;
   bit          sender_calm = 1'b0;
   bit          drain_next = 1'b0;
   logic [7:0]  last_queued = 8'd0;

   uart_boot_loader_stream i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_write_addr  (rsp_write_addr),
      .rsp_write_data  (rsp_write_data),
      .rsp_launch_addr (rsp_launch_addr)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic result_type advance_loader(input logic [7:0] rx);
      result_type  res;
      logic [31:0] shifted;
      res = '0;
      res.kind = KIND_ECHO;
      shifted = {24'd0, rx} << {hdr_count[1:0], 3'b000};
      case (load_mode)
         MODE_CMD: begin
            res.echo_byte = rx;
            if (rx == CHAR_CR) begin
               if (prev_cmd_byte == CHAR_B) begin
                  load_mode = MODE_HDR;
                  hdr_count = 3'd0;
                  cursor = 32'd0;
                  blob_left = 32'd0;
               end else if (prev_cmd_byte == CHAR_R) begin
                  load_mode = MODE_RUN;
                  hdr_count = 3'd0;
                  cursor = 32'd0;
               end else begin
                  res.kind = KIND_LINE;
               end
            end
            prev_cmd_byte = rx;
         end
         MODE_HDR: begin
            res.kind = KIND_HDR;
            if (hdr_count < 3'd4) cursor = cursor | shifted;
            else blob_left = blob_left | shifted;
            hdr_count = hdr_count + 3'd1;
            if (hdr_count == 3'd0) load_mode = (blob_left == 32'd0) ? MODE_CMD : MODE_DATA;
         end
         MODE_DATA: begin
            res.kind = KIND_WRITE;
            res.write_addr = cursor;
            res.write_data = rx;
            cursor = cursor + 32'd1;
            blob_left = blob_left - 32'd1;
            if (blob_left == 32'd0) load_mode = MODE_CMD;
         end
         default: begin
            cursor = cursor | shifted;
            hdr_count = hdr_count + 3'd1;
            if (hdr_count >= 3'd4) begin
               res.kind = KIND_LAUNCH;
               res.launch_addr = cursor;
               hdr_count = 3'd0;
               load_mode = MODE_CMD;
            end else begin
               res.kind = KIND_HDR;
            end
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                  $realtime, what, got, want);
   endtask

   task automatic queue_byte(input logic [7:0] value);
      rx_item_type item;
      item.value = value;
      item.gap_after = sender_calm ? 5'd0 : 5'($urandom_range(0, 17));
      item.drain_first = drain_next;
      drain_next = 1'b0;
      pending_bytes.push_back(item);
      last_queued = value;
      bytes_queued++;
   endtask

   task automatic queue_word(input logic [31:0] word);
      for (int i = 0; i < 4; i++) queue_byte(word[8*i +: 8]);
   endtask

   task automatic queue_blob(input logic [31:0] base, input logic [31:0] length,
                             input int data_count);
      queue_byte(CHAR_B);
      queue_byte(CHAR_CR);
      queue_word(base);
      queue_word(length);
      for (int i = 0; i < data_count; i++) queue_byte(8'($urandom));
   endtask

   // driver: predict on accept, then present the next item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'd0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(advance_loader(req_rx_byte));
            bytes_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0 &&
                         !(pending_bytes[0].drain_first && expected_results.size() > 0)) begin
               next_item = pending_bytes.pop_front();
               gap_left = next_item.gap_after;
               req_valid <= 1'b1;
               req_rx_byte <= next_item.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result item against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", 32'(rsp_result_kind), 32'd0);
            end else begin
               expected_now = expected_results.pop_front();
               if (rsp_result_kind !== expected_now.kind)
                  report_mismatch("result_kind", 32'(rsp_result_kind), 32'(expected_now.kind));
               if (rsp_echo_byte !== expected_now.echo_byte)
                  report_mismatch("echo_byte", 32'(rsp_echo_byte), 32'(expected_now.echo_byte));
               if (rsp_write_addr !== expected_now.write_addr)
                  report_mismatch("write_addr", rsp_write_addr, expected_now.write_addr);
               if (rsp_write_data !== expected_now.write_data)
                  report_mismatch("write_data", 32'(rsp_write_data), 32'(expected_now.write_data));
               if (rsp_launch_addr !== expected_now.launch_addr)
                  report_mismatch("launch_addr", rsp_launch_addr, expected_now.launch_addr);
               if (rsp_result_kind <= 3'd4) kind_seen[rsp_result_kind]++;
            end
            results_seen++;
            if (results_seen % 40 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
            stall_left = receiver_calm ? 0 : $urandom_range(0, 17);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= hold_request || (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // long receiver hold-offs while the sender keeps offering
   initial begin
      for (int h = 0; h < 2; h++) begin
         while (bytes_accepted < 250 + 300 * h) @(posedge clock);
         hold_request <= 1'b1;
         repeat (200) @(posedge clock);
         hold_request <= 1'b0;
         hold_offs++;
      end
   end

   initial begin
      int          choice;
      int          burst;
      int          data_count;
      logic [31:0] base;
      logic [7:0]  noise;

      reset = 1'b1;

      queue_byte(CHAR_CR);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(CHAR_R);
      queue_byte(CHAR_CR);
      queue_word(32'hFF00_FF00);
      queue_blob(32'hFFFF_FFFF, 32'd2, 2);
      queue_blob(32'h8000_0001, 32'd0, 0);
      queue_byte(CHAR_CR);

      while (bytes_queued < RANDOM_BYTES) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         drain_next = ($urandom_range(0, 19) == 0);
         if (drain_next) drain_pauses++;
         choice = $urandom_range(0, 99);
         if (choice < 45) begin
            base = $urandom;
            if ($urandom_range(0, 7) == 0) base = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
            data_count = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(0, 12);
            queue_blob(base, 32'(data_count), data_count);
         end else if (choice < 65) begin
            queue_byte(CHAR_R);
            queue_byte(CHAR_CR);
            queue_word($urandom);
         end else if (choice < 85) begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst; i++) begin
               noise = 8'($urandom);
               if ($urandom_range(0, 3) == 0) noise = CHAR_CR;
               if (noise == CHAR_CR && (last_queued == CHAR_B || last_queued == CHAR_R))
                  noise = 8'h08;
               queue_byte(noise);
            end
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  queue_byte(CHAR_B);
                  queue_byte(8'h08);
                  queue_byte(CHAR_CR);
               end
               1: begin
                  queue_byte(CHAR_R);
                  queue_byte(8'($urandom_range(0, 12)));
                  queue_byte(CHAR_CR);
               end
               default: begin
                  queue_byte(8'h0A);
                  queue_byte(CHAR_CR);
                  queue_byte(CHAR_CR);
               end
            endcase
         end
      end

      // end inside a huge blob so the upper length bytes see nonzero values
      sender_calm = 1'b0;
      drain_next = 1'b1;
      drain_pauses++;
      queue_blob($urandom, {8'($urandom_range(1, 255)), 24'($urandom)}, 40);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < bytes_queued) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", 32'(expected_results.size()), 32'd0);

      $display("covered %0d bytes: %0d echoes, %0d line ends, %0d memory writes, %0d header bytes, %0d launches",
               bytes_accepted, kind_seen[KIND_ECHO], kind_seen[KIND_LINE],
               kind_seen[KIND_WRITE], kind_seen[KIND_HDR], kind_seen[KIND_LAUNCH]);
      $display("long receiver hold-offs: %0d, sender drain pauses: %0d, mismatches: %0d",
               hold_offs, drain_pauses, mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ubl_pkg.sv
rtl/core/ubl_core.sv
rtl/core/uart_boot_loader_stream.sv
rtl/core/uart_boot_loader_stream_chk.sv
sim/tb_uart_boot_loader_stream.sv
